>>> src/bifb_pkg.sv
// Shared types and constants for the boot information framebuffer tag parser.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bifb_pkg;

  // Result status codes.
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_NOT_RGB   = 3'd1;
  localparam logic [2:0] STATUS_BAD_BPP   = 3'd2;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
  localparam logic [2:0] STATUS_MALFORMED = 3'd4;

  // Tag type codes and the values that the framebuffer tag must carry.
  localparam logic [31:0] TAG_END         = 32'd0;
  localparam logic [31:0] TAG_FRAMEBUFFER = 32'd8;
  localparam logic [7:0]  FB_TYPE_RGB     = 8'd1;
  localparam logic [7:0]  FB_BPP_WANTED   = 8'd32;

  // Input word as carried by the input channel.
  typedef struct packed {
    logic [31:0] info_word;
    logic        start_req;
  } in_t;

  // One parse result.
  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] fb_address;
    logic [31:0] fb_pitch;
    logic [31:0] fb_width;
    logic [31:0] fb_height;
    logic [7:0]  fb_bpp;
    logic [7:0]  red_pos;
    logic [7:0]  green_pos;
    logic [7:0]  blue_pos;
  } res_t;

endpackage

>>> src/bifb_in_if.sv
// Valid/ready channel that carries boot information words into the parser.
// Depends on bifb_pkg for the payload type.
`timescale 1ns / 1ps

interface bifb_in_if;
  import bifb_pkg::*;

  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/bifb_out_if.sv
// Valid/ready channel that carries parse results out of the parser.
// Depends on bifb_pkg for the payload type.
`timescale 1ns / 1ps

interface bifb_out_if;
  import bifb_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/bifb_out_reg.sv
// Result register of the framebuffer tag parser: holds one result until taken.
// Depends on bifb_pkg and bifb_out_if.
`timescale 1ns / 1ps

module bifb_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  bifb_pkg::res_t res_i,
  output logic           free_o,
  bifb_out_if.source     out_o
);
  import bifb_pkg::*;

  logic valid_q, valid_d;
  res_t data_q;

  // The slot can take a new result when empty or when it empties this cycle.
  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (out_o.ready) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = data_q;

endmodule

>>> src/boot_info_framebuffer_tag_parser.sv
// Top level of the boot information framebuffer tag parser.
// Depends on bifb_pkg, bifb_in_if, bifb_out_if and bifb_out_reg.
`timescale 1ns / 1ps

// Usage
// The block reads a boot information structure as a stream of 32-bit
// little-endian words on in_i, one word per handshake. A word with start_req
// set begins a new structure and carries its total size in bytes; the word
// after it is reserved and the first tag begins at byte 8. Tags are walked
// with each size rounded up to a multiple of 8. The first framebuffer tag is
// captured and checked, and at most one result word per structure appears on
// out_o: ok, not RGB, wrong depth, not found or malformed tag size. Words
// before the first start, or after the result, are dropped without a result,
// and a start in the middle of a structure abandons the old one.
// Every word is handled in the cycle it is accepted, so one word per cycle
// is sustained; the result is registered and shows on out_o in the cycle
// after the word that decides it. The single result register sets the stall
// behavior: while a result waits and out_o.ready is low, in_i.ready drops,
// and it stays high whenever that register is empty or being emptied.
// After reset the block is idle until a start word and no result is pending.

module boot_info_framebuffer_tag_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  bifb_in_if.sink    in_i,
  bifb_out_if.source out_o
);
  import bifb_pkg::*;

  // Offsets of the framebuffer tag fields from the start of the tag.
  localparam logic [31:0] OFF_TYPE    = 32'd0;
  localparam logic [31:0] OFF_SIZE    = 32'd4;
  localparam logic [31:0] OFF_ADDR_LO = 32'd8;
  localparam logic [31:0] OFF_ADDR_HI = 32'd12;
  localparam logic [31:0] OFF_PITCH   = 32'd16;
  localparam logic [31:0] OFF_WIDTH   = 32'd20;
  localparam logic [31:0] OFF_HEIGHT  = 32'd24;
  localparam logic [31:0] OFF_BPP     = 32'd28;
  localparam logic [31:0] OFF_RG_POS  = 32'd32;
  localparam logic [31:0] OFF_B_POS   = 32'd36;

  // Walk state.
  logic [31:0] offset_q, offset_d;
  logic [31:0] total_q, total_d;
  logic [31:0] tag_begin_q, tag_begin_d;
  logic        is_fb_q, is_fb_d;
  logic        done_q, done_d;

  // Captured framebuffer fields.
  logic [63:0] address_q, address_d;
  logic [31:0] pitch_q, pitch_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic [7:0]  bpp_q, bpp_d;
  logic [7:0]  red_q, red_d;
  logic [7:0]  green_q, green_d;

  logic        accept;
  logic        emit;
  logic [2:0]  status;
  logic [7:0]  blue;
  logic [31:0] word;
  logic [31:0] rel;
  logic [32:0] size_round;
  logic [33:0] next_begin;
  logic        out_free;
  res_t        result;

  assign word   = in_i.data.info_word;
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = out_free;

  // Offset of the current word within the current tag, and where the next
  // tag would begin, computed without wrapping.
  assign rel        = offset_q - tag_begin_q;
  assign size_round = ({1'b0, word} + 33'd7) & ~33'd7;
  assign next_begin = {2'b00, tag_begin_q} + {1'b0, size_round};

  always_comb begin
    offset_d    = offset_q;
    total_d     = total_q;
    tag_begin_d = tag_begin_q;
    is_fb_d     = is_fb_q;
    done_d      = done_q;
    address_d   = address_q;
    pitch_d     = pitch_q;
    width_d     = width_q;
    height_d    = height_q;
    bpp_d       = bpp_q;
    red_d       = red_q;
    green_d     = green_q;
    emit        = 1'b0;
    status      = STATUS_OK;
    blue        = 8'd0;

    if (accept) begin
      if (in_i.data.start_req) begin
        address_d   = 64'd0;
        pitch_d     = 32'd0;
        width_d     = 32'd0;
        height_d    = 32'd0;
        bpp_d       = 8'd0;
        red_d       = 8'd0;
        green_d     = 8'd0;
        total_d     = word;
        offset_d    = 32'd4;
        tag_begin_d = 32'd8;
        is_fb_d     = 1'b0;
        done_d      = 1'b0;
        if (word <= 32'd8) begin
          emit   = 1'b1;
          status = STATUS_NOT_FOUND;
        end
      end else if (!done_q) begin
        offset_d = offset_q + 32'd4;
        // The reserved word and anything below byte 8 carry nothing.
        if (offset_q >= 32'd8) begin
          if (rel == OFF_TYPE) begin
            is_fb_d = (word == TAG_FRAMEBUFFER);
            if (word == TAG_END) begin
              emit   = 1'b1;
              status = STATUS_NOT_FOUND;
            end
          end else if (!is_fb_q) begin
            // Other tags only matter for their size word.
            if (rel == OFF_SIZE) begin
              if (word < 32'd8) begin
                emit   = 1'b1;
                status = STATUS_MALFORMED;
              end else if (next_begin >= {2'b00, total_q}) begin
                emit   = 1'b1;
                status = STATUS_NOT_FOUND;
              end else begin
                tag_begin_d = next_begin[31:0];
              end
            end
          end else begin
            unique case (rel)
              OFF_ADDR_LO: address_d[31:0]  = word;
              OFF_ADDR_HI: address_d[63:32] = word;
              OFF_PITCH:   pitch_d          = word;
              OFF_WIDTH:   width_d          = word;
              OFF_HEIGHT:  height_d         = word;
              OFF_BPP: begin
                bpp_d = word[7:0];
                if (word[15:8] != FB_TYPE_RGB) begin
                  emit   = 1'b1;
                  status = STATUS_NOT_RGB;
                end
              end
              OFF_RG_POS: begin
                red_d   = word[7:0];
                green_d = word[23:16];
              end
              OFF_B_POS: begin
                emit   = 1'b1;
                blue   = word[7:0];
                status = (bpp_q != FB_BPP_WANTED) ? STATUS_BAD_BPP : STATUS_OK;
              end
              default: begin
              end
            endcase
          end
        end
      end
      if (emit) begin
        done_d = 1'b1;
      end
    end
  end

  // The result reports the captured fields as they stand after this word.
  always_comb begin
    result.status     = status;
    result.fb_address = address_d;
    result.fb_pitch   = pitch_d;
    result.fb_width   = width_d;
    result.fb_height  = height_d;
    result.fb_bpp     = bpp_d;
    result.red_pos    = red_d;
    result.green_pos  = green_d;
    result.blue_pos   = blue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= 32'd0;
      total_q     <= 32'd0;
      tag_begin_q <= 32'd8;
      is_fb_q     <= 1'b0;
      done_q      <= 1'b1;
    end else begin
      offset_q    <= offset_d;
      total_q     <= total_d;
      tag_begin_q <= tag_begin_d;
      is_fb_q     <= is_fb_d;
      done_q      <= done_d;
    end
  end

  // Captured fields are cleared by every start, so they need no reset.
  always_ff @(posedge clk_i) begin
    address_q <= address_d;
    pitch_q   <= pitch_d;
    width_q   <= width_d;
    height_q  <= height_d;
    bpp_q     <= bpp_d;
    red_q     <= red_d;
    green_q   <= green_d;
  end

  bifb_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (emit),
    .res_i  (result),
    .free_o (out_free),
    .out_o  (out_o)
  );

  // A result always ends the structure.
  assert property (@(posedge clk_i) disable iff (!rst_ni) emit |=> done_q)
    else $error("parser still walking after a result");

  // The input side never stalls while the result register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !out_o.valid |-> in_i.ready)
    else $error("input stalled with an empty result register");

  // Tags begin on 8-byte boundaries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) tag_begin_q[2:0] == 3'd0)
    else $error("tag start not 8-byte aligned");

  // While walking, the current tag lies inside the structure.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !done_q |-> tag_begin_q < total_q)
    else $error("walking a tag past the total size");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the boot information framebuffer tag parser.
// Depends on bifb_pkg, bifb_in_if, bifb_out_if and the parser RTL under src.
`timescale 1ns / 1ps

module tb_top;
  import bifb_pkg::*;

  // How an input word is checked: against the predictor, as a word that must
  // leave no result, or against a status typed into the directed table.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_TYPED
  } check_e;

  typedef struct {
    in_t         item;
    check_e      check;
    logic [2:0]  status;
  } dir_row_t;

  // Byte offsets inside a tag and the layout of the structure header.
  localparam logic [31:0] FIRST_TAG     = 32'd8;
  localparam logic [31:0] MIN_TAG_BYTES = 32'd8;
  localparam logic [31:0] OFF_TYPE      = 32'd0;
  localparam logic [31:0] OFF_SIZE      = 32'd4;
  localparam logic [31:0] OFF_ADDR_LO   = 32'd8;
  localparam logic [31:0] OFF_ADDR_HI   = 32'd12;
  localparam logic [31:0] OFF_PITCH     = 32'd16;
  localparam logic [31:0] OFF_WIDTH     = 32'd20;
  localparam logic [31:0] OFF_HEIGHT    = 32'd24;
  localparam logic [31:0] OFF_FORMAT    = 32'd28;
  localparam logic [31:0] OFF_COLOR     = 32'd32;
  localparam logic [31:0] OFF_BLUE      = 32'd36;

  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 20;

  logic clk_i = 1'b0;
  logic rst_ni;

  bifb_in_if  in_if ();
  bifb_out_if out_if ();

  boot_info_framebuffer_tag_parser DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Parser state as the predictor tracks it; the values are the reset state,
  // which stays idle until the first start word.
  logic [31:0] cur_off    = '0;
  logic [31:0] size_total = '0;
  logic [31:0] tag_base   = FIRST_TAG;
  logic [31:0] kind_now   = '0;
  bit          parse_idle = 1'b1;
  logic [63:0] cap_addr   = '0;
  logic [31:0] cap_pitch  = '0;
  logic [31:0] cap_width  = '0;
  logic [31:0] cap_height = '0;
  logic [7:0]  cap_bpp    = '0;
  logic [7:0]  cap_red    = '0;
  logic [7:0]  cap_green  = '0;

  res_t        pending_results[$];
  res_t        oldest_result;
  in_t         struct_words[$];
  dir_row_t    directed_rows[$];
  int unsigned err_count    = 0;
  int unsigned active_items = 0;
  int unsigned struct_count = 0;

  // Idling controls shared by the sender, the receiver and the hold-off.
  bit tx_idle  = 1'b1;
  bit rx_idle  = 1'b1;
  bit rx_hold  = 1'b0;
  bit hold_arm = 1'b0;

  // Builds the result word from the captured fields and closes the structure.
  task automatic close_parse(input logic [2:0] st, input logic [7:0] blue,
                             output bit emits, output res_t r);
    r.status     = st;
    r.fb_address = cap_addr;
    r.fb_pitch   = cap_pitch;
    r.fb_width   = cap_width;
    r.fb_height  = cap_height;
    r.fb_bpp     = cap_bpp;
    r.red_pos    = cap_red;
    r.green_pos  = cap_green;
    r.blue_pos   = blue;
    parse_idle   = 1'b1;
    emits        = 1'b1;
  endtask

  // Predicts the effect of one accepted word. active is low when the parser
  // simply drops the word.
  task automatic parse_word(input in_t item, output bit emits, output bit active,
                            output res_t r);
    logic [31:0] w;
    logic [31:0] off;
    logic [31:0] rel;
    logic [63:0] nxt;
    w      = item.info_word;
    emits  = 1'b0;
    active = 1'b1;
    r      = '0;
    if (item.start_req) begin
      cap_addr   = '0;
      cap_pitch  = '0;
      cap_width  = '0;
      cap_height = '0;
      cap_bpp    = '0;
      cap_red    = '0;
      cap_green  = '0;
      size_total = w;
      cur_off    = 32'd4;
      tag_base   = FIRST_TAG;
      kind_now   = '0;
      parse_idle = 1'b0;
      if (w <= FIRST_TAG) close_parse(STATUS_NOT_FOUND, 8'd0, emits, r);
    end else if (parse_idle) begin
      active = 1'b0;
    end else begin
      off     = cur_off;
      cur_off = off + 32'd4;
      if (off >= FIRST_TAG) begin
        rel = off - tag_base;
        if (rel == OFF_TYPE) begin
          kind_now = w;
          if (w == TAG_END) close_parse(STATUS_NOT_FOUND, 8'd0, emits, r);
        end else if (kind_now != TAG_FRAMEBUFFER) begin
          if (rel == OFF_SIZE) begin
            if (w < MIN_TAG_BYTES) begin
              close_parse(STATUS_MALFORMED, 8'd0, emits, r);
            end else begin
              // The next tag start is worked out in 64 bits so it cannot wrap.
              nxt = {32'd0, tag_base} + (({32'd0, w} + 64'd7) & ~64'd7);
              if (nxt >= {32'd0, size_total}) close_parse(STATUS_NOT_FOUND, 8'd0, emits, r);
              else tag_base = nxt[31:0];
            end
          end
        end else begin
          unique case (rel)
            OFF_ADDR_LO: cap_addr[31:0]  = w;
            OFF_ADDR_HI: cap_addr[63:32] = w;
            OFF_PITCH:   cap_pitch       = w;
            OFF_WIDTH:   cap_width       = w;
            OFF_HEIGHT:  cap_height      = w;
            OFF_FORMAT: begin
              cap_bpp = w[7:0];
              if (w[15:8] != FB_TYPE_RGB) close_parse(STATUS_NOT_RGB, 8'd0, emits, r);
            end
            OFF_COLOR: begin
              cap_red   = w[7:0];
              cap_green = w[23:16];
            end
            OFF_BLUE: begin
              close_parse((cap_bpp != FB_BPP_WANTED) ? STATUS_BAD_BPP : STATUS_OK,
                          w[7:0], emits, r);
            end
            default: ;
          endcase
        end
      end
    end
  endtask

  // Offers one word after a random gap when tx_idle is set, waits for the
  // handshake and records what the parser should answer.
  task automatic send_word(input in_t item, input check_e check,
                           input logic [2:0] status);
    int unsigned gap;
    bit          emits;
    bit          active;
    res_t        r;
    gap = tx_idle ? $urandom_range(0, 18) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    parse_word(item, emits, active, r);
    if (active) active_items++;
    unique case (check)
      CHK_MODEL: if (emits) pending_results.push_back(r);
      CHK_TYPED: begin
        r        = '0;
        r.status = status;
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic add_row(input logic [31:0] w, input bit s, input check_e check,
                         input logic [2:0] status);
    dir_row_t row;
    row.item.info_word = w;
    row.item.start_req = s;
    row.check          = check;
    row.status         = status;
    directed_rows.push_back(row);
  endtask

  task automatic push_word(input logic [31:0] w, input bit s);
    in_t item;
    item.info_word = w;
    item.start_req = s;
    struct_words.push_back(item);
  endtask

  // Field values lean toward all zeros and all ones.
  function automatic logic [31:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 32'd0;
    if (sel == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Appends a tag that is not a framebuffer tag, padded with filler words if 8 <= sz <= 48.
  task automatic add_plain_tag(inout logic [31:0] pos, input logic [31:0] sz);
    logic [31:0] kind;
    logic [31:0] pad;
    kind = $urandom_range(1, 21);
    if (kind == TAG_FRAMEBUFFER) kind = 32'd22;
    if ($urandom_range(0, 9) == 0) kind = $urandom;
    push_word(kind, 1'b0);
    push_word(sz, 1'b0);
    pad = (sz + 32'd7) & ~32'd7;
    if (sz >= MIN_TAG_BYTES && sz <= 32'd48) begin
      repeat ((pad - 32'd8) / 4) push_word($urandom, 1'b0);
    end
    pos = pos + pad;
  endtask

  // Fills struct_words with one structure. Most are well formed with random
  // content; the rest end early, are malformed, abandoned, or plain noise.
  task automatic build_structure();
    int unsigned pick;
    int unsigned keep;
    logic [31:0] pos;
    logic [31:0] total;
    logic [31:0] sz;
    logic [7:0]  bpp;
    logic [7:0]  fmt;
    struct_words.delete();
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      repeat ($urandom_range(1, 6)) push_word($urandom, $urandom_range(0, 7) == 0);
      return;
    end
    push_word(32'd0, 1'b1);
    push_word(pick_word(), 1'b0);
    pos = FIRST_TAG;
    if (pick >= 76 && pick < 82) begin
      // A total size that leaves no room for any tag.
      struct_words[0].info_word = $urandom_range(0, 8);
      repeat ($urandom_range(0, 3)) push_word($urandom, 1'b0);
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      sz = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(8, 40);
      add_plain_tag(pos, sz);
    end
    total = ($urandom_range(0, 3) == 0) ? $urandom : pos + $urandom_range(1, 64);
    if (pick < 50 || pick >= 82) begin
      bpp = ($urandom_range(0, 9) < 7) ? FB_BPP_WANTED : 8'($urandom);
      fmt = ($urandom_range(0, 4) != 0) ? FB_TYPE_RGB : 8'($urandom);
      push_word(TAG_FRAMEBUFFER, 1'b0);
      push_word(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100), 1'b0);
      push_word(pick_word(), 1'b0);
      push_word(pick_word(), 1'b0);
      push_word(pick_word(), 1'b0);
      push_word(pick_word(), 1'b0);
      push_word(pick_word(), 1'b0);
      push_word({16'($urandom), fmt, bpp}, 1'b0);
      push_word($urandom, 1'b0);
      push_word(pick_word(), 1'b0);
    end else if (pick < 60) begin
      push_word(TAG_END, 1'b0);
    end else if (pick < 68) begin
      add_plain_tag(pos, $urandom_range(0, 7));
    end else begin
      // The last tag reaches the total size, so the walk stops on it.
      add_plain_tag(pos, $urandom_range(8, 40));
      total = $urandom_range(9, pos);
    end
    struct_words[0].info_word = total;
    if (pick >= 82) begin
      // Cut short; the next start abandons what is left.
      keep = $urandom_range(1, struct_words.size() - 1);
      while (struct_words.size() > keep) struct_words.delete(struct_words.size() - 1);
    end else begin
      repeat ($urandom_range(0, 2)) push_word($urandom, 1'b0);
    end
  endtask

  // Compares one field of a result word with its expected value.
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  // Result monitor: every result word taken from the parser is matched with
  // the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected, status %0d", out_if.data.status);
        err_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("status", 64'(oldest_result.status), 64'(out_if.data.status));
        check_field("fb_address", oldest_result.fb_address, out_if.data.fb_address);
        check_field("fb_pitch", 64'(oldest_result.fb_pitch), 64'(out_if.data.fb_pitch));
        check_field("fb_width", 64'(oldest_result.fb_width), 64'(out_if.data.fb_width));
        check_field("fb_height", 64'(oldest_result.fb_height),
                    64'(out_if.data.fb_height));
        check_field("fb_bpp", 64'(oldest_result.fb_bpp), 64'(out_if.data.fb_bpp));
        check_field("red_pos", 64'(oldest_result.red_pos), 64'(out_if.data.red_pos));
        check_field("green_pos", 64'(oldest_result.green_pos),
                    64'(out_if.data.green_pos));
        check_field("blue_pos", 64'(oldest_result.blue_pos), 64'(out_if.data.blue_pos));
      end
    end
  end

  // Result receiver: stalls a random number of cycles before each result word
  // when rx_idle is set, and holds ready low for as long as the hold-off is on.
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rx_idle ? $urandom_range(0, 18) : 0;
      @(negedge clk_i);
      if (stall > 0 || rx_hold) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
        while (rx_hold) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  // One long hold-off on the result side while words keep coming, so that
  // the result register stays full and the parser has to stall its input.
  initial begin
    wait (hold_arm);
    repeat ($urandom_range(10, 100)) @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    rst_ni      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Words before any start and after a result are dropped.
    add_row(32'hFFFF_FFFF, 1'b0, CHK_NONE, STATUS_OK);
    add_row(32'd8, 1'b1, CHK_TYPED, STATUS_NOT_FOUND);
    add_row(32'd0, 1'b0, CHK_NONE, STATUS_OK);
    // Largest total size, then a tag size below the minimum.
    add_row(32'hFFFF_FFFF, 1'b1, CHK_NONE, STATUS_OK);
    add_row(32'hFFFF_FFFF, 1'b0, CHK_NONE, STATUS_OK);
    add_row(32'hFFFF_FFFF, 1'b0, CHK_NONE, STATUS_OK);
    add_row(32'd7, 1'b0, CHK_TYPED, STATUS_MALFORMED);
    // The next tag would start exactly at the total size.
    add_row(32'd24, 1'b1, CHK_NONE, STATUS_OK);
    add_row(32'd0, 1'b0, CHK_NONE, STATUS_OK);
    add_row(32'd3, 1'b0, CHK_NONE, STATUS_OK);
    add_row(32'd16, 1'b0, CHK_TYPED, STATUS_NOT_FOUND);
    // End tag.
    add_row(32'd64, 1'b1, CHK_NONE, STATUS_OK);
    add_row(32'd0, 1'b0, CHK_NONE, STATUS_OK);
    add_row(TAG_END, 1'b0, CHK_TYPED, STATUS_NOT_FOUND);
    // A structure abandoned by a new start whose framebuffer tag lies past
    // its total size, with the fields at their extremes.
    add_row(32'd100, 1'b1, CHK_NONE, STATUS_OK);
    add_row(32'd0, 1'b0, CHK_NONE, STATUS_OK);
    add_row(32'd16, 1'b1, CHK_NONE, STATUS_OK);
    add_row(32'd0, 1'b0, CHK_NONE, STATUS_OK);
    add_row(TAG_FRAMEBUFFER, 1'b0, CHK_MODEL, STATUS_OK);
    add_row(32'd0, 1'b0, CHK_MODEL, STATUS_OK);
    add_row(32'hFFFF_FFFF, 1'b0, CHK_MODEL, STATUS_OK);
    add_row(32'd0, 1'b0, CHK_MODEL, STATUS_OK);
    add_row(32'hFFFF_FFFF, 1'b0, CHK_MODEL, STATUS_OK);
    add_row(32'd0, 1'b0, CHK_MODEL, STATUS_OK);
    add_row(32'hFFFF_FFFF, 1'b0, CHK_MODEL, STATUS_OK);
    add_row(32'hFFFF_0120, 1'b0, CHK_MODEL, STATUS_OK);
    add_row(32'hFFFF_FF00, 1'b0, CHK_MODEL, STATUS_OK);
    add_row(32'hFFFF_FFFF, 1'b0, CHK_MODEL, STATUS_OK);
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].item, directed_rows[i].check, directed_rows[i].status);
    end

    // Random part, with the idling of each side changed every few structures.
    active_items = 0;
    while (active_items < RANDOM_ITEMS) begin
      if (struct_count % 5 == 0) {tx_idle, rx_idle} = 2'($urandom_range(0, 3));
      if (active_items > 300) hold_arm = 1'b1;
      build_structure();
      foreach (struct_words[i]) send_word(struct_words[i], CHK_MODEL, STATUS_OK);
      struct_count++;
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
